### src/hsv_to_rgb_converter_unit_defines.svh
// Assertion macros shared by the HSV to RGB converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define HSV_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define HSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define HSV_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define HSV_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/hsvrgb_pkg.sv
// Package with the fixed-point constants and transfer payload types of the HSV to RGB converter.
package hsvrgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FX_W      = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * FX_W;
    localparam int H6_W      = FRAC_BITS + 3;
    localparam int SECTOR_W  = 3;
    localparam int CH_W      = 8;
    localparam int BYTE_W    = FX_W + CH_W;

    localparam logic [FX_W-1:0] ONE_FX = FX_W'(1) << FRAC_BITS;

    typedef logic [FX_W-1:0]     fx_t;
    typedef logic [SECTOR_W-1:0] sector_t;

    localparam sector_t SECTOR_0 = 3'd0;
    localparam sector_t SECTOR_1 = 3'd1;
    localparam sector_t SECTOR_2 = 3'd2;
    localparam sector_t SECTOR_3 = 3'd3;
    localparam sector_t SECTOR_4 = 3'd4;
    localparam sector_t SECTOR_5 = 3'd5;

    typedef struct packed {
        logic [FX_W-1:0] hue;
        logic [FX_W-1:0] saturation;
        logic [FX_W-1:0] brightness;
    } hsv_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

endpackage

### src/hsv_to_rgb_converter_unit.sv
// Top level of the HSV to RGB converter: a four-stage pipeline that turns one pixel a cycle.
// Throughput is one pixel per cycle; the pipeline advances as a whole whenever the output
// register is empty or its result is being taken, so a stalled sink freezes every stage.
// Reset (rst_n, asynchronous, active low) clears only the stage valid bits.
`include "hsv_to_rgb_converter_unit_defines.svh"

module hsv_to_rgb_converter_unit
    import hsvrgb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic hsv_valid,
    output logic hsv_ready,
    input  hsv_t hsv,
    output logic rgb_valid,
    input  logic rgb_ready,
    output rgb_t rgb
);

    // The whole pipeline moves forward together. Because the last stage is a register,
    // a new pixel can be taken while the previous result still waits, as long as the
    // sink takes it in the same cycle.
    logic advance;
    assign advance   = !rgb_valid || rgb_ready;
    assign hsv_ready = advance;

    // Stage 1: clamp the inputs and split six times the hue into sector and fraction.
    logic      s1_valid_reg, s1_valid_next;
    fx_t       s1_sat_reg, s1_sat_next;
    fx_t       s1_val_reg, s1_val_next;
    sector_t   s1_sector_reg, s1_sector_next;
    logic [FRAC_BITS-1:0] s1_frac_reg, s1_frac_next;

    logic [H6_W-1:0] hue6;
    logic [FRAC_BITS-1:0] hue_eff;

    always_comb
    begin
        // A hue of one or more wraps to zero.
        hue_eff = (hsv.hue >= ONE_FX) ? '0 : hsv.hue[FRAC_BITS-1:0];
        // Six times the hue as a shift-and-add: 4h + 2h.
        hue6 = (H6_W'(hue_eff) << 2) + (H6_W'(hue_eff) << 1);

        s1_valid_next  = hsv_valid;
        s1_sat_next    = (hsv.saturation > ONE_FX) ? ONE_FX : hsv.saturation;
        s1_val_next    = (hsv.brightness > ONE_FX) ? ONE_FX : hsv.brightness;
        s1_sector_next = hue6[H6_W-1:FRAC_BITS];
        s1_frac_next   = hue6[FRAC_BITS-1:0];
    end

    // Stage 2: the two saturation products s*f and s*(1-f), plus 1-s.
    logic    s2_valid_reg, s2_valid_next;
    fx_t     s2_val_reg, s2_val_next;
    sector_t s2_sector_reg, s2_sector_next;
    fx_t     s2_inv_s_reg, s2_inv_s_next;
    fx_t     s2_sf_reg, s2_sf_next;
    fx_t     s2_sinvf_reg, s2_sinvf_next;

    logic [PROD_W-1:0] prod_sf;
    logic [PROD_W-1:0] prod_sinvf;

    always_comb
    begin
        prod_sf    = PROD_W'(s1_sat_reg) * PROD_W'(s1_frac_reg);
        prod_sinvf = PROD_W'(s1_sat_reg) * PROD_W'(ONE_FX - FX_W'(s1_frac_reg));

        s2_valid_next  = s1_valid_reg;
        s2_val_next    = s1_val_reg;
        s2_sector_next = s1_sector_reg;
        s2_inv_s_next  = ONE_FX - s1_sat_reg;
        s2_sf_next     = prod_sf[FRAC_BITS+FX_W-1:FRAC_BITS];
        s2_sinvf_next  = prod_sinvf[FRAC_BITS+FX_W-1:FRAC_BITS];
    end

    // Stage 3: scale by brightness to get p, q and t.
    logic    s3_valid_reg, s3_valid_next;
    fx_t     s3_val_reg, s3_val_next;
    sector_t s3_sector_reg, s3_sector_next;
    fx_t     s3_p_reg, s3_p_next;
    fx_t     s3_q_reg, s3_q_next;
    fx_t     s3_t_reg, s3_t_next;

    logic [PROD_W-1:0] prod_p;
    logic [PROD_W-1:0] prod_q;
    logic [PROD_W-1:0] prod_t;

    always_comb
    begin
        prod_p = PROD_W'(s2_val_reg) * PROD_W'(s2_inv_s_reg);
        prod_q = PROD_W'(s2_val_reg) * PROD_W'(ONE_FX - s2_sf_reg);
        prod_t = PROD_W'(s2_val_reg) * PROD_W'(ONE_FX - s2_sinvf_reg);

        s3_valid_next  = s2_valid_reg;
        s3_val_next    = s2_val_reg;
        s3_sector_next = s2_sector_reg;
        s3_p_next      = prod_p[FRAC_BITS+FX_W-1:FRAC_BITS];
        s3_q_next      = prod_q[FRAC_BITS+FX_W-1:FRAC_BITS];
        s3_t_next      = prod_t[FRAC_BITS+FX_W-1:FRAC_BITS];
    end

    // Stage 4: pick the channel order for the sector and convert each channel to a byte.
    logic rgb_valid_reg, rgb_valid_next;
    rgb_t rgb_reg, rgb_next;

    fx_t red_fx, green_fx, blue_fx;

    // floor(x * 255) as (x << 8) - x, saturated to one byte.
    function automatic logic [CH_W-1:0] to_byte(input fx_t x);
        logic [BYTE_W-1:0] scaled;
        logic [BYTE_W-FRAC_BITS-1:0] whole;
        scaled = (BYTE_W'(x) << CH_W) - BYTE_W'(x);
        whole  = scaled[BYTE_W-1:FRAC_BITS];
        return (whole > (BYTE_W-FRAC_BITS)'(255)) ? 8'hFF : whole[CH_W-1:0];
    endfunction

    always_comb
    begin
        case (s3_sector_reg)
            SECTOR_0:
            begin
                red_fx = s3_val_reg; green_fx = s3_t_reg;   blue_fx = s3_p_reg;
            end
            SECTOR_1:
            begin
                red_fx = s3_q_reg;   green_fx = s3_val_reg; blue_fx = s3_p_reg;
            end
            SECTOR_2:
            begin
                red_fx = s3_p_reg;   green_fx = s3_val_reg; blue_fx = s3_t_reg;
            end
            SECTOR_3:
            begin
                red_fx = s3_p_reg;   green_fx = s3_q_reg;   blue_fx = s3_val_reg;
            end
            SECTOR_4:
            begin
                red_fx = s3_t_reg;   green_fx = s3_p_reg;   blue_fx = s3_val_reg;
            end
            default:
            begin
                red_fx = s3_val_reg; green_fx = s3_p_reg;   blue_fx = s3_q_reg;
            end
        endcase

        rgb_valid_next = s3_valid_reg;
        rgb_next.red   = to_byte(red_fx);
        rgb_next.green = to_byte(green_fx);
        rgb_next.blue  = to_byte(blue_fx);
    end

    // Valid bits are the only state that reset touches.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            rgb_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            rgb_valid_reg <= rgb_valid_next;
        end
    end

    // Payload registers load whenever the pipeline moves; bubbles carry don't-care data.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sat_reg    <= s1_sat_next;
            s1_val_reg    <= s1_val_next;
            s1_sector_reg <= s1_sector_next;
            s1_frac_reg   <= s1_frac_next;

            s2_val_reg    <= s2_val_next;
            s2_sector_reg <= s2_sector_next;
            s2_inv_s_reg  <= s2_inv_s_next;
            s2_sf_reg     <= s2_sf_next;
            s2_sinvf_reg  <= s2_sinvf_next;

            s3_val_reg    <= s3_val_next;
            s3_sector_reg <= s3_sector_next;
            s3_p_reg      <= s3_p_next;
            s3_q_reg      <= s3_q_next;
            s3_t_reg      <= s3_t_next;

            rgb_reg       <= rgb_next;
        end
    end

    assign rgb_valid = rgb_valid_reg;
    assign rgb       = rgb_reg;

    // A wrapped hue must never produce a sector above five.
    `HSV_ASSERT_IMPLIES(a_sector_range, clk, rst_n, s1_valid_reg, s1_sector_reg <= SECTOR_5)
    // An accepted pixel lands in the first stage on the next edge.
    `HSV_ASSERT_NEXT(a_accept_enters, clk, rst_n, hsv_valid && hsv_ready, s1_valid_reg)
    // A stalled pipeline keeps every stage's occupancy.
    `HSV_ASSERT_NEXT(a_stall_holds, clk, rst_n, !advance,
        $stable({s1_valid_reg, s2_valid_reg, s3_valid_reg, rgb_valid_reg}))

endmodule
